### sv/circular_queue_min_max_search_macros.svh
// ---------------------------------------------------------------------------
// Circular queue min/max/search assertion macros
// Short forms for concurrent checks clocked on aclk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_MIN_MAX_SEARCH_MACROS_SVH
`define CIRCULAR_QUEUE_MIN_MAX_SEARCH_MACROS_SVH

// Same-cycle implication.
`define CQMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CQMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/cqmm_pkg.sv
// ---------------------------------------------------------------------------
// Circular queue min/max/search package
// Transaction structs, operation and status codes, and the scan token that
// travels along the ring of slot cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqmm_pkg;

    localparam int DATA_W = 32;
    localparam int SLOT_W = 3;
    localparam int OCC_W  = 4;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_QUERY  = 2'd2,
        OP_SEARCH = 2'd3
    } cqmm_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } cqmm_status_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value;
    } cqmm_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
        logic [OCC_W-1:0]         occupancy;
    } cqmm_out_t;

    // Scan token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     search;
        logic                     found;
        logic [DATA_W-1:0]        key;
        logic signed [DATA_W-1:0] min_v;
        logic signed [DATA_W-1:0] max_v;
        logic [SLOT_W-1:0]        slot;
    } cqmm_tok_t;

endpackage

### sv/cqmm_cell.sv
// ---------------------------------------------------------------------------
// Circular queue slot cell
// Holds one queue slot and updates the scan token passing through it: folds
// the slot into the running min/max, or matches it against the search key.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqmm_cell #(
    parameter int IDX = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [cqmm_pkg::DATA_W-1:0] wr_data,
    input  logic                        kill,
    input  cqmm_pkg::cqmm_tok_t         tok_in,
    output cqmm_pkg::cqmm_tok_t         tok_out
);
    import cqmm_pkg::*;

    logic signed [DATA_W-1:0] slot_reg;
    cqmm_tok_t                tok_reg;
    cqmm_tok_t                tok_next;

    // Store the enqueued word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg <= wr_data;
        end
    end

    // Fold this slot into the passing token
    always_comb begin
        tok_next = tok_in;
        if (kill) begin
            tok_next.valid = 1'b0;
        end else if (tok_in.valid) begin
            tok_next.first = 1'b0;
            if (tok_in.search) begin
                if (!tok_in.found && (slot_reg == tok_in.key)) begin
                    tok_next.found = 1'b1;
                    tok_next.slot  = SLOT_W'(IDX);
                end
            end else if (tok_in.first) begin
                tok_next.min_v = slot_reg;
                tok_next.max_v = slot_reg;
            end else begin
                if (slot_reg < tok_in.min_v) begin
                    tok_next.min_v = slot_reg;
                end
                if (slot_reg > tok_in.max_v) begin
                    tok_next.max_v = slot_reg;
                end
            end
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### sv/circular_queue_min_max_search.sv
// Enqueue, dequeue and a query or search on an empty queue: the result is
// registered on the accepting edge and moves to the output stage from S_EMIT.
// Query and search over N live entries: the token walks one slot cell per cycle
// from the head to the newest entry, then the result passes through S_EMIT.
// A new transaction is taken once the previous result sits in the output stage.
// Reset clears head, tail, count and the token ring; slot contents are kept.
// ---------------------------------------------------------------------------
// Circular queue with min/max query and search
// Control, head/tail pointers and occupancy, driving a ring of slot cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_queue_min_max_search_macros.svh"

module circular_queue_min_max_search #(
    parameter int DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cqmm_pkg::cqmm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cqmm_pkg::cqmm_out_t m_data
);
    import cqmm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic                     inject_reg, inject_next;
    logic                     search_reg, search_next;
    logic [DATA_W-1:0]        key_reg, key_next;
    cqmm_out_t                res_reg, res_next;
    cqmm_out_t                out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     accept;
    logic                     enq_fire;
    logic                     kill;
    cqmm_tok_t                init_tok;
    cqmm_tok_t                cap_tok;
    cqmm_tok_t                tok_in_w  [DEPTH];
    cqmm_tok_t                tok_out_w [DEPTH];
    logic [DEPTH-1:0]         tok_valid_vec;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Token launched at the head cell
    always_comb begin
        init_tok        = '0;
        init_tok.valid  = 1'b1;
        init_tok.first  = 1'b1;
        init_tok.search = search_reg;
        init_tok.key    = key_reg;
    end

    // Ring of slot cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam int PREV = (gi == 0) ? DEPTH - 1 : gi - 1;

        assign tok_in_w[gi] = (inject_reg && (head_reg == PTR_W'(gi))) ?
                              init_tok : tok_out_w[PREV];

        cqmm_cell #(
            .IDX(gi)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (enq_fire && (tail_reg == PTR_W'(gi))),
            .wr_data (key_next),
            .kill    (kill),
            .tok_in  (tok_in_w[gi]),
            .tok_out (tok_out_w[gi])
        );

        assign tok_valid_vec[gi] = tok_out_w[gi].valid;
    end

    // Collect the one live token at the end of a scan
    always_comb begin
        cap_tok = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (tok_out_w[i].valid) begin
                cap_tok = cap_tok | tok_out_w[i];
            end
        end
    end

    // Control
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        inject_next    = 1'b0;
        search_next    = search_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        enq_fire       = 1'b0;
        kill           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next    = s_data.value;
                    search_next = (s_data.operation == OP_SEARCH);
                    res_next    = '0;
                    state_next  = S_EMIT;
                    case (s_data.operation)
                        OP_ENQ: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                enq_fire   = 1'b1;
                                tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ?
                                             '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DEQ: begin
                            if (count_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                head_next  = (head_reg == PTR_W'(DEPTH - 1)) ?
                                             '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_QUERY, OP_SEARCH: begin
                            if (count_reg == '0) begin
                                res_next.status = (s_data.operation == OP_SEARCH) ?
                                                  ST_NOT_FOUND : ST_OK;
                            end else begin
                                scan_cnt_next = count_reg;
                                inject_next   = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        default: begin
                            res_next.status = ST_OK;
                        end
                    endcase
                    res_next.occupancy = OCC_W'(count_next);
                end
            end
            S_SCAN: begin
                if (scan_cnt_reg == '0) begin
                    // Token has passed the newest entry: capture and clear the ring
                    kill               = 1'b1;
                    res_next           = '0;
                    res_next.occupancy = OCC_W'(count_reg);
                    if (search_reg) begin
                        res_next.status = cap_tok.found ? ST_OK : ST_NOT_FOUND;
                        res_next.slot   = cap_tok.found ? cap_tok.slot : '0;
                    end else begin
                        res_next.status    = ST_OK;
                        res_next.min_value = cap_tok.min_v;
                        res_next.max_value = cap_tok.max_v;
                    end
                    state_next = S_EMIT;
                end else begin
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            S_EMIT: begin
                // Move the result into the output stage once it is free
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            inject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            inject_reg    <= inject_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        search_reg <= search_next;
        key_reg    <= key_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    `CQMM_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH), "occupancy above depth")
    `CQMM_ASSERT_SAME(a_single_token, 1'b1, $onehot0(tok_valid_vec), "more than one scan token")
    `CQMM_ASSERT_SAME(a_token_at_end, (state_reg == S_SCAN) && (scan_cnt_reg == '0), $onehot(tok_valid_vec), "no token at end of scan")
    `CQMM_ASSERT_SAME(a_idle_ring_empty, state_reg == S_IDLE, tok_valid_vec == '0, "token alive while idle")
    `CQMM_ASSERT_SAME(a_ptr_count, head_reg == tail_reg, (count_reg == '0) || (count_reg == CNT_W'(DEPTH)), "pointers disagree with count")
    `CQMM_ASSERT_NEXT(a_ring_cleared, kill, tok_valid_vec == '0, "ring not cleared after capture")

endmodule
